// ----- rtl/core/tlca_pkg.sv -----
`timescale 1ns / 1ps

package tlca_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int LIFT_LEVELS = 10;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int DEPTH_W     = 10;
    localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]                   node_t;
    typedef logic [DEPTH_W-1:0]                  depth_t;
    typedef logic [LVL_W-1:0]                    lvl_t;
    typedef logic [LIFT_LEVELS-1:0][NODE_W-1:0]  row_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_ACCEPT,
        DP_DEPTH,
        DP_LIFT1,
        DP_LIFT2,
        DP_FINAL,
        DP_LSTART,
        DP_LEVEL,
        DP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        lvl_t   lvl;
        node_t  clr_addr;
    } dp_cmd_t;

endpackage

// ----- rtl/core/tlca_in_if.sv -----
`timescale 1ns / 1ps

interface tlca_in_if
    import tlca_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  opcode;
    node_t node_x;
    node_t node_y;

    modport source (output valid, output opcode, output node_x, output node_y, input ready);
    modport sink   (input valid, input opcode, input node_x, input node_y, output ready);
endinterface

// ----- rtl/core/tlca_out_if.sv -----
`timescale 1ns / 1ps

interface tlca_out_if
    import tlca_pkg::*;
();
    logic  valid;
    logic  ready;
    node_t ancestor;

    modport source (output valid, output ancestor, input ready);
    modport sink   (input valid, input ancestor, output ready);
endinterface

// ----- rtl/core/tlca_ctrl.sv -----
`timescale 1ns / 1ps

module tlca_ctrl
    import tlca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_opcode,
    input  logic    in_x_zero,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEPTH,
        S_LIFT1,
        S_LIFT2,
        S_FINAL,
        S_LSTART,
        S_LOAD,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    lvl_t   lvl_reg, lvl_next;
    node_t  clr_reg, clr_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = DP_IDLE;
        cmd.lvl        = lvl_reg;
        cmd.clr_addr   = clr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (clr_reg == node_t'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = DP_ACCEPT;
                    if (in_opcode == OP_QUERY)
                    begin
                        state_next = S_DEPTH;
                    end
                    else if (!in_x_zero)
                    begin
                        state_next = S_LSTART;
                    end
                end
            end
            S_DEPTH:
            begin
                cmd.op     = DP_DEPTH;
                lvl_next   = lvl_t'(LIFT_LEVELS - 1);
                state_next = S_LIFT1;
            end
            S_LIFT1:
            begin
                cmd.op = DP_LIFT1;
                if (lvl_reg == '0)
                begin
                    lvl_next   = lvl_t'(LIFT_LEVELS - 1);
                    state_next = S_LIFT2;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            S_LIFT2:
            begin
                cmd.op = DP_LIFT2;
                if (lvl_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            S_FINAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_FINAL;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LSTART:
            begin
                cmd.op = DP_LSTART;
                if (LIFT_LEVELS > 1)
                begin
                    lvl_next   = lvl_t'(1);
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_LOAD:
            begin
                cmd.op = DP_LEVEL;
                if (lvl_reg == lvl_t'(LIFT_LEVELS - 1))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.op     = DP_WRITE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lvl_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/tlca_datapath.sv -----
`timescale 1ns / 1ps

module tlca_datapath
    import tlca_pkg::*;
(
    input  logic    clk,
    input  dp_cmd_t cmd,
    input  logic    in_opcode,
    input  node_t   in_node_x,
    input  node_t   in_node_y,
    output node_t   ancestor
);

    // one row per node: all power-of-two ancestors side by side
    row_t   jump_mem  [NODE_COUNT];
    depth_t depth_mem [NODE_COUNT];

    node_t  a_reg, a_next;
    node_t  b_reg, b_next;
    node_t  x_reg, x_next;
    depth_t k_reg, k_next;
    depth_t dnew_reg, dnew_next;
    row_t   row_new_reg, row_new_next;
    node_t  anc_reg, anc_next;

    // read data always tracks the current a/b registers
    row_t   row_a_reg, row_b_reg;
    depth_t da_reg, db_reg;

    lvl_t   lvl_prev;
    node_t  level_val;

    assign lvl_prev  = cmd.lvl - 1'b1;
    assign level_val = (a_reg == x_reg) ? row_new_reg[lvl_prev] : row_a_reg[lvl_prev];

    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        k_next       = k_reg;
        dnew_next    = dnew_reg;
        row_new_next = row_new_reg;
        anc_next     = anc_reg;

        case (cmd.op)
            DP_ACCEPT:
            begin
                a_next          = (in_opcode == OP_QUERY) ? in_node_x : in_node_y;
                b_next          = in_node_y;
                x_next          = in_node_x;
                row_new_next    = '0;
                row_new_next[0] = in_node_y;
            end
            DP_DEPTH:
            begin
                if (da_reg < db_reg)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                    k_next = db_reg - da_reg;
                end
                else
                begin
                    k_next = da_reg - db_reg;
                end
            end
            DP_LIFT1:
            begin
                if (k_reg[cmd.lvl])
                begin
                    a_next = row_a_reg[cmd.lvl];
                end
            end
            DP_LIFT2:
            begin
                if (row_a_reg[cmd.lvl] != row_b_reg[cmd.lvl])
                begin
                    a_next = row_a_reg[cmd.lvl];
                    b_next = row_b_reg[cmd.lvl];
                end
            end
            DP_FINAL:
            begin
                anc_next = (a_reg == b_reg) ? a_reg : row_a_reg[0];
            end
            DP_LSTART:
            begin
                dnew_next = (da_reg == DEPTH_MAX) ? DEPTH_MAX : da_reg + 1'b1;
            end
            DP_LEVEL:
            begin
                row_new_next[cmd.lvl] = level_val;
                a_next                = level_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        k_reg       <= k_next;
        dnew_reg    <= dnew_next;
        row_new_reg <= row_new_next;
        anc_reg     <= anc_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_CLEAR)
        begin
            jump_mem[cmd.clr_addr]  <= '0;
            depth_mem[cmd.clr_addr] <= '0;
        end
        else if (cmd.op == DP_WRITE)
        begin
            jump_mem[x_reg]  <= row_new_reg;
            depth_mem[x_reg] <= dnew_reg;
        end
        row_a_reg <= jump_mem[a_next];
        row_b_reg <= jump_mem[b_next];
        da_reg    <= depth_mem[a_next];
        db_reg    <= depth_mem[b_next];
    end

    assign ancestor = anc_reg;

endmodule

// ----- rtl/core/tree_lca_binary_lifting_top.sv -----
`timescale 1ns / 1ps

// lowest common ancestor by binary lifting over a stored tree
// in_ch carries one transaction per item: opcode 0 loads node_x under parent node_y,
// opcode 1 asks for the lowest common ancestor of node_x and node_y
// out_ch carries one transaction per query (field ancestor); loads give none
// node 0 is the root; parents must be loaded before their children
// load: accept, depth, then the level steps that fill the new row one level at a time
//   from the chain of dependent jump table reads, then the write into the tables
// query: accept, depth compare, lift steps down to equal depth, joint lift steps,
//   then the result step
// each lift step is one registered read of the jump table row memory
// one item is in work at a time; in_ch.ready is high only while the block is free
// reset: a clearing pass over all NODE_COUNT (1024) entries zeroes the jump table and
//   depth store, and no item is accepted until it ends
// the result sits in an output register; the block takes the next item while
//   it waits, and a later query stalls in its result cycle until out_ch frees up

module tree_lca_binary_lifting_top
    import tlca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tlca_in_if.sink      in_ch,
    tlca_out_if.source   out_ch
);

    // controller to datapath command bundle
    dp_cmd_t cmd;

    tlca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_x_zero (in_ch.node_x == '0),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // jump table, depth store and the lifting registers
    tlca_datapath u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .in_opcode (in_ch.opcode),
        .in_node_x (in_ch.node_x),
        .in_node_y (in_ch.node_y),
        .ancestor  (out_ch.ancestor)
    );

endmodule

// ----- sim/tlca_checker.sv -----
`timescale 1ns / 1ps

module tlca_checker
    import tlca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tlca_in_if    in_ch,
    tlca_out_if   out_ch,
    output int    mismatches,
    output int    waiting,
    output int    compared
);

    // shadow copy of the tree: power-of-two ancestors and depth per node
    node_t  anc_row  [NODE_COUNT][LIFT_LEVELS];
    depth_t node_lvl [NODE_COUNT];
    node_t  lca_fifo [$];

    int     bad_cnt;
    int     ok_cnt;
    node_t  want;

    function automatic void add_node(node_t x, node_t y);
        int d;
        int j;
        if (x == '0)
            return;
        d = int'(node_lvl[y]) + 1;
        node_lvl[x] = (d > int'(DEPTH_MAX)) ? DEPTH_MAX : depth_t'(d);
        anc_row[x][0] = y;
        // in increasing order, so a self parent fills the row with itself
        for (j = 1; j < LIFT_LEVELS; j++)
            anc_row[x][j] = anc_row[anc_row[x][j-1]][j-1];
    endfunction

    function automatic node_t common_ancestor(node_t a, node_t b);
        node_t  t;
        node_t  ua;
        node_t  ub;
        depth_t gap;
        int     j;
        if (node_lvl[a] < node_lvl[b])
        begin
            t = a;
            a = b;
            b = t;
        end
        gap = node_lvl[a] - node_lvl[b];
        for (j = LIFT_LEVELS - 1; j >= 0; j--)
            if (gap[j])
                a = anc_row[a][j];
        if (a == b)
            return a;
        for (j = LIFT_LEVELS - 1; j >= 0; j--)
        begin
            ua = anc_row[a][j];
            ub = anc_row[b][j];
            if (ua != ub)
            begin
                a = ua;
                b = ub;
            end
        end
        return anc_row[a][0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int r;
        int c;
        if (!rst_n)
        begin
            for (r = 0; r < NODE_COUNT; r++)
            begin
                node_lvl[r] = '0;
                for (c = 0; c < LIFT_LEVELS; c++)
                    anc_row[r][c] = '0;
            end
            lca_fifo.delete();
            bad_cnt = 0;
            ok_cnt  = 0;
        end
        else
        begin
            // results first: they always belong to an older query
            if (out_ch.valid && out_ch.ready)
            begin
                if (lca_fifo.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("%0t: ancestor %0d arrived with no query waiting",
                                 $realtime, out_ch.ancestor);
                end
                else
                begin
                    want = lca_fifo.pop_front();
                    ok_cnt++;
                    if (out_ch.ancestor !== want)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("%0t: ancestor mismatch, expected %0d, got %0d",
                                     $realtime, want, out_ch.ancestor);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.opcode == OP_QUERY)
                    lca_fifo = {lca_fifo, common_ancestor(in_ch.node_x, in_ch.node_y)};
                else
                    add_node(in_ch.node_x, in_ch.node_y);
            end
        end
        mismatches <= bad_cnt;
        compared   <= ok_cnt;
        waiting    <= lca_fifo.size();
    end

endmodule

// ----- sim/tb_tree_lca_binary_lifting_top.sv -----
`timescale 1ns / 1ps

module tb_tree_lca_binary_lifting_top;
    import tlca_pkg::*;

    // no transaction on either channel for this long means the block hung;
    // covers the clearing pass after reset and the long receiver hold
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    // nodes hung as a bushy tree before the rest go into one long chain
    localparam int BUSH_NODES  = 250;
    // reload steps that push the chain depth past the saturation point
    localparam int SAT_LOADS   = 320;

    logic clk;
    logic rst_n;

    tlca_in_if  in_ch ();
    tlca_out_if out_ch ();

    int mismatches;
    int waiting;
    int compared;
    int loads_sent;
    int queries_sent;

    // hold_req asks the receiver for one long hold-off, calm turns all idling off
    logic  hold_req;
    logic  calm;

    // nodes already hung in the tree, and a shuffled list of all non-root nodes
    node_t tree_pool [$];
    node_t order     [NODE_COUNT-1];

    tree_lca_binary_lifting_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    tlca_checker lca_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .waiting    (waiting),
        .compared   (compared)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // one transaction on in_ch, with an optional idle burst in front;
    // returns at the edge where the item is taken
    task automatic send_item(input logic op, input node_t x, input node_t y);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.node_x <= x;
        in_ch.node_y <= y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (op == OP_QUERY)
            queries_sent++;
        else
            loads_sent++;
    endtask

    function automatic node_t pick_node();
        return tree_pool[$urandom_range(0, tree_pool.size() - 1)];
    endfunction

    function automatic node_t any_node();
        return node_t'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    // mostly pairs of hung nodes, sometimes an arbitrary node or the same node twice
    task automatic random_query();
        node_t a;
        node_t b;
        a = pick_node();
        b = pick_node();
        case ($urandom_range(0, 9))
            0: a = any_node();
            1: b = any_node();
            2: b = a;
            default: ;
        endcase
        send_item(OP_QUERY, a, b);
    endtask

    // broken loads: root load, self parent, arbitrary parent, out-of-order node
    task automatic noise_load();
        node_t a;
        a = pick_node();
        case ($urandom_range(0, 3))
            0: send_item(OP_LOAD, '0, any_node());
            1: send_item(OP_LOAD, a, a);
            2: send_item(OP_LOAD, a, any_node());
            default: send_item(OP_LOAD, any_node(), pick_node());
        endcase
    endtask

    // receiver: short random stalls, one long hold-off on request, none when calm
    initial
    begin : receiver
        int   stall;
        logic hold_taken;
        out_ch.ready <= 1'b0;
        stall = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                // long hold-off: the block keeps one result and then blocks its input
                hold_taken = 1'b1;
                stall = 0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                if (stall == 0)
                    out_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int    i;
        int    j;
        int    span;
        node_t t;
        node_t prev;
        node_t x;

        rst_n        <= 1'b0;
        hold_req     <= 1'b0;
        calm         <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_LOAD;
        in_ch.node_x <= '0;
        in_ch.node_y <= '0;
        loads_sent   = 0;
        queries_sent = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty tree, extremes of the node range, root load,
        // orphan parent, self parent, reload with stale rows below it
        send_item(OP_QUERY, 10'd0,    10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd1023, 10'd5);
        send_item(OP_LOAD,  10'd0,    10'd5);
        send_item(OP_LOAD,  10'd1,    10'd0);
        send_item(OP_LOAD,  10'd2,    10'd1);
        send_item(OP_LOAD,  10'd1023, 10'd2);
        send_item(OP_LOAD,  10'd512,  10'd1);
        send_item(OP_LOAD,  10'd700,  10'd600);
        send_item(OP_QUERY, 10'd1023, 10'd512);
        send_item(OP_QUERY, 10'd512,  10'd1023);
        send_item(OP_QUERY, 10'd2,    10'd1023);
        send_item(OP_QUERY, 10'd1023, 10'd0);
        send_item(OP_QUERY, 10'd700,  10'd1023);
        send_item(OP_LOAD,  10'd3,    10'd3);
        send_item(OP_QUERY, 10'd3,    10'd2);
        send_item(OP_LOAD,  10'd2,    10'd512);
        send_item(OP_QUERY, 10'd1023, 10'd512);
        send_item(OP_LOAD,  10'd341,  10'd1023);
        send_item(OP_LOAD,  10'd682,  10'd341);
        send_item(OP_QUERY, 10'd682,  10'd700);
        send_item(OP_QUERY, 10'd341,  10'd682);

        tree_pool = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd512, 10'd1023,
                      10'd341, 10'd682, 10'd700};

        // shuffle every non-root node once
        for (i = 0; i < NODE_COUNT - 1; i++)
            order[i] = node_t'(i + 1);
        for (i = NODE_COUNT - 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end

        // bushy tree in parent-first order, parents often among the newest nodes
        for (i = 0; i < BUSH_NODES; i++)
        begin
            if (i == 60)
            begin
                // receiver holds off while queries keep coming
                hold_req <= 1'b1;
                repeat (4) random_query();
            end
            while ($urandom_range(0, 9) < 3)
                random_query();
            if ($urandom_range(0, 15) == 0)
                noise_load();
            span = (tree_pool.size() > 8) ? 7 : tree_pool.size() - 1;
            if ($urandom_range(0, 1) == 1)
                prev = tree_pool[tree_pool.size() - 1 - $urandom_range(0, span)];
            else
                prev = pick_node();
            send_item(OP_LOAD, order[i], prev);
            tree_pool = {tree_pool, order[i]};
        end

        // the rest of the nodes as one long chain under the newest bushy node
        prev = tree_pool[tree_pool.size() - 1];
        for (i = BUSH_NODES; i < NODE_COUNT - 1; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                random_query();
            send_item(OP_LOAD, order[i], prev);
            prev = order[i];
            tree_pool = {tree_pool, order[i]};
        end

        // keep extending the chain by reloading nodes, so the depth saturates
        // and many rows go stale; the second half runs with no idling at all
        for (i = 0; i < SAT_LOADS; i++)
        begin
            if (i == SAT_LOADS / 2)
                calm <= 1'b1;
            while ($urandom_range(0, 9) < 3)
                random_query();
            if ($urandom_range(0, 15) == 0)
                noise_load();
            x = order[$urandom_range(0, NODE_COUNT - 2)];
            send_item(OP_LOAD, x, prev);
            prev = x;
        end

        // drain: wait for every expected ancestor, then let the block settle
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run: %0d loads and %0d queries driven, %0d ancestors compared",
                 loads_sent, queries_sent, compared);
        $display("tree went from bushy to one chain past the depth limit, with reloads, ",
                 "self parents, orphans and a long output hold-off");
        if (waiting != 0)
            $display("%0d expected ancestors never arrived", waiting);
        if (mismatches == 0 && waiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
